// ===== hdl/rcc_pkg.sv =====
`default_nettype none
package rcc_pkg;

  // Field formats.
  localparam int COORD_W  = 32;
  localparam int DIR_W    = 16;
  localparam int DIR_FRAC = 14;
  localparam int RAD_W    = 31;
  localparam int R2_W     = 2 * RAD_W;

  // Radial arithmetic widths.
  localparam int PROD_W   = COORD_W + DIR_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int A_W      = 32;

  // Square root unit: one result bit per stage.
  localparam int SQ_IN_W  = 93;
  localparam int SQ_RES_W = 94;
  localparam int ROOT_W   = 47;
  localparam int SQ_STEPS = 47;

  // Divider unit: one quotient bit per stage.
  localparam int NUM_W     = 50;
  localparam int MAG_W     = 49;
  localparam int DEN_W     = 32;
  localparam int REM_W     = MAG_W + DIR_FRAC;
  localparam int Q_W       = 32;
  localparam int DIV_STEPS = 32;

  // Interval parameters carry one guard bit beyond the infinite value.
  localparam int VAL_W = COORD_W + 2;
  localparam logic signed [VAL_W-1:0] VAL_INF = {2'b01, {COORD_W{1'b0}}};
  localparam logic signed [VAL_W-1:0] SAT_HI  = {3'b000, {(COORD_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] SAT_LO  = {3'b111, {(COORD_W-1){1'b0}}};
  localparam logic [COORD_W-1:0] MISS_ENTER = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] MISS_EXIT  = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_ZLOW   = 2'd1,
    REG_ZHIGH  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [DEN_W-1:0] den;
  } div_in_t;

  typedef struct packed {
    logic [Q_W-1:0] quo;
    logic           big;
  } div_out_t;

endpackage
`default_nettype wire

// ===== hdl/rcc_isqrt.sv =====
`default_nettype none
module rcc_isqrt import rcc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [SQ_IN_W-1:0]  radicand,
  output logic      [ROOT_W-1:0]   root
);

  logic [SQ_RES_W-1:0] op_r  [1:SQ_STEPS];
  logic [SQ_RES_W-1:0] res_r [1:SQ_STEPS];

  // Digit-by-digit square root, one result bit per stage, highest bit first.
  for (genvar i = 1; i <= SQ_STEPS; i++) begin : g_step
    localparam int SH = 2 * (SQ_STEPS - i);
    logic [SQ_RES_W-1:0] op_p;
    logic [SQ_RES_W-1:0] res_p;
    logic [SQ_RES_W-1:0] cand;
    logic [SQ_RES_W:0]   diff;

    if (i == 1) begin : g_first
      assign op_p  = SQ_RES_W'(radicand);
      assign res_p = '0;
    end else begin : g_next
      assign op_p  = op_r[i-1];
      assign res_p = res_r[i-1];
    end

    assign cand = res_p + (SQ_RES_W'(1) << SH);
    assign diff = {1'b0, op_p} - {1'b0, cand};

    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[SQ_RES_W]) begin
          op_r[i]  <= diff[SQ_RES_W-1:0];
          res_r[i] <= (res_p >> 1) + (SQ_RES_W'(1) << SH);
        end else begin
          op_r[i]  <= op_p;
          res_r[i] <= res_p >> 1;
        end
      end
    end
  end

  assign root = res_r[SQ_STEPS][ROOT_W-1:0];

endmodule
`default_nettype wire

// ===== hdl/rcc_div.sv =====
`default_nettype none
module rcc_div import rcc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     en,
  input  wire div_in_t  din,
  output div_out_t      dout
);

  logic [REM_W-1:0] rem_r [0:DIV_STEPS];
  logic [DEN_W-1:0] den_r [0:DIV_STEPS];
  logic [Q_W-1:0]   quo_r [0:DIV_STEPS];
  logic             big_r [1:DIV_STEPS];

  // Input stage: scale the numerator by the direction fraction.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {din.mag, {DIR_FRAC{1'b0}}};
      den_r[0] <= din.den;
      quo_r[0] <= '0;
    end
  end

  // Restoring division, one quotient bit per stage, highest bit first.
  for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_step
    localparam int K = DIV_STEPS - i;
    logic [REM_W:0] sh;
    logic [REM_W:0] trial;

    assign sh    = {{(REM_W+1-DEN_W){1'b0}}, den_r[i-1]} << K;
    assign trial = {1'b0, rem_r[i-1]} - sh;

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[i] <= den_r[i-1];
        if (!trial[REM_W]) begin
          rem_r[i] <= trial[REM_W-1:0];
          quo_r[i] <= quo_r[i-1] | (Q_W'(1) << K);
        end else begin
          rem_r[i] <= rem_r[i-1];
          quo_r[i] <= quo_r[i-1];
        end
      end
    end

    // A quotient of 2^Q_W or more cannot be formed by the stages; flag it.
    if (i == 1) begin : g_big
      always_ff @(posedge clk) begin
        if (en) begin
          big_r[i] <= ({1'b0, rem_r[0]} >= {den_r[0], {Q_W{1'b0}}});
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          big_r[i] <= big_r[i-1];
        end
      end
    end
  end

  assign dout.quo = quo_r[DIV_STEPS];
  assign dout.big = big_r[DIV_STEPS];

endmodule
`default_nettype wire

// ===== hdl/ray_cylinder_clip_unit.sv =====
// Clips one ray (origin Q16.16, direction Q2.14) against a cylinder about the z axis of
// radius cyl_radius, bounded by the planes z_low and z_high, and returns the entry and
// exit parameters with a hit flag; a miss gives entry at the largest and exit at the
// smallest value. One ray is taken every clock cycle while the output is not held; each
// ray passes through the 47-stage square root and the 33-stage dividers in line.
// The whole pipeline holds while a result waits on out_tready. Registers are to be
// written only while no ray is in flight.
`default_nettype none
module ray_cylinder_clip_unit import rcc_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // org_x, org_y, org_z (32 bits each), dir_x, dir_y, dir_z (16 bits each)
  input  wire logic [143:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // s_enter, s_exit (32 bits each)
  output logic [63:0]       out_tdata,
  // hit
  output logic [0:0]        out_tuser,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [3:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  typedef struct packed {
    logic signed [COORD_W:0] zin_num;
    logic signed [COORD_W:0] zout_num;
    logic [DIR_W-1:0]        zden;
    logic                    zzero;
    logic                    zinside;
  } zq_t;

  typedef struct packed {
    logic                    valid;
    logic [A_W-1:0]          dxx;
    logic [A_W-1:0]          dyy;
    logic signed [PROD_W-1:0] oxdy;
    logic signed [PROD_W-1:0] oydx;
    logic signed [PROD_W-1:0] oxdx;
    logic signed [PROD_W-1:0] oydy;
    logic [2*COORD_W-1:0]    oxx;
    logic [2*COORD_W-1:0]    oyy;
    logic signed [COORD_W:0] zlo_d;
    logic signed [COORD_W:0] zhi_d;
    logic signed [DIR_W-1:0] dz;
  } s1_t;

  typedef struct packed {
    logic                    valid;
    logic [A_W-1:0]          a;
    logic signed [SUM_W-1:0] c;
    logic signed [SUM_W-1:0] b;
    logic                    in_rad;
    zq_t                     z;
  } s2_t;

  typedef struct packed {
    logic                    valid;
    logic [A_W-1:0]          a;
    logic signed [SUM_W-1:0] b;
    logic                    in_rad;
    logic                    azero;
    logic [47:0]             chh;
    logic [47:0]             chl;
    logic [47:0]             cll;
    logic [62:0]             arh;
    logic [62:0]             arl;
    zq_t                     z;
  } s3_t;

  typedef struct packed {
    logic                    valid;
    logic [A_W-1:0]          a;
    logic signed [SUM_W-1:0] b;
    logic                    in_rad;
    logic                    azero;
    logic [95:0]             c2;
    logic [93:0]             ar2;
    zq_t                     z;
  } s4_t;

  typedef struct packed {
    logic                    valid;
    logic [A_W-1:0]          a;
    logic signed [SUM_W-1:0] b;
    logic                    in_rad;
    logic                    byp;
    zq_t                     z;
  } sa_t;

  typedef struct packed {
    logic valid;
    logic byp;
    logic in_rad;
    logic rneg_in;
    logic rneg_out;
    logic zneg_in;
    logic zneg_out;
    logic zzero;
    logic zinside;
  } sb_t;

  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] rin;
    logic signed [VAL_W-1:0] rout;
    logic signed [VAL_W-1:0] zin;
    logic signed [VAL_W-1:0] zout;
  } f_t;

  logic [RAD_W-1:0]          cyl_radius_r;
  logic signed [COORD_W-1:0] z_low_r;
  logic signed [COORD_W-1:0] z_high_r;
  logic [R2_W-1:0]           r2_r;
  logic                      cfg_wr;

  logic en;
  logic signed [COORD_W-1:0] ox, oy, oz;
  logic signed [DIR_W-1:0]   dx, dy, dz;

  s1_t s1_nxt, s1_r;
  s2_t s2_nxt, s2_r;
  s3_t s3_nxt, s3_r;
  s4_t s4_nxt, s4_r;
  sa_t s5_nxt;
  logic [SQ_IN_W-1:0] disc_nxt, disc_r;
  sa_t sa_r [0:SQ_STEPS];
  sb_t sb_nxt;
  sb_t sb_r [0:DIV_STEPS];
  f_t  f_nxt, f_r;

  logic [48:0] cabs;
  logic [23:0] ch, cl;
  logic [ROOT_W-1:0] root;
  logic signed [NUM_W-1:0] nb, num_in, num_out, abs_in, abs_out;
  logic [COORD_W:0] zabs_in, zabs_out;
  div_in_t  rdin_in, rdin_out, zdin_in, zdin_out;
  div_out_t rq_in, rq_out, zq_in, zq_out;

  logic signed [VAL_W-1:0] ent, ext;
  logic miss;
  logic out_tvalid_r;
  logic [COORD_W-1:0] s_enter_nxt, s_exit_nxt, s_enter_r, s_exit_r;
  logic hit_nxt, hit_r;

  // Turns a divider result into a signed parameter, clamped to the infinite value.
  function automatic logic signed [VAL_W-1:0] div_val(input logic neg, input div_out_t d);
    logic [VAL_W-1:0] m;
    m = d.big ? VAL_W'(VAL_INF) : VAL_W'(d.quo);
    return neg ? -m : m;
  endfunction

  function automatic logic [COORD_W-1:0] sat(input logic signed [VAL_W-1:0] x);
    logic signed [VAL_W-1:0] y;
    y = x;
    if (x > SAT_HI) begin
      y = SAT_HI;
    end else if (x < SAT_LO) begin
      y = SAT_LO;
    end
    return y[COORD_W-1:0];
  endfunction

  // Configuration registers; pready is always high.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cyl_radius_r <= RAD_W'(65536);
      z_low_r      <= -COORD_W'(65536);
      z_high_r     <= COORD_W'(65536);
    end else if (cfg_wr) begin
      case (reg_idx_t'(cfg_paddr[3:2]))
        REG_RADIUS: cyl_radius_r <= cfg_pwdata[RAD_W-1:0];
        REG_ZLOW:   z_low_r      <= cfg_pwdata;
        REG_ZHIGH:  z_high_r     <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(cfg_paddr[3:2]))
      REG_RADIUS: cfg_prdata = {1'b0, cyl_radius_r};
      REG_ZLOW:   cfg_prdata = z_low_r;
      REG_ZHIGH:  cfg_prdata = z_high_r;
      default:    cfg_prdata = '0;
    endcase
  end

  // The squared radius follows the register in the next cycle.
  always_ff @(posedge clk) begin
    r2_r <= cyl_radius_r * cyl_radius_r;
  end

  // The whole pipeline advances together unless the output beat is held.
  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  assign ox = in_tdata[31:0];
  assign oy = in_tdata[63:32];
  assign oz = in_tdata[95:64];
  assign dx = in_tdata[111:96];
  assign dy = in_tdata[127:112];
  assign dz = in_tdata[143:128];

  // Stage 1: products of the ray and the z plane offsets.
  always_comb begin
    s1_nxt.valid = in_tvalid;
    s1_nxt.dxx   = dx * dx;
    s1_nxt.dyy   = dy * dy;
    s1_nxt.oxdy  = ox * dy;
    s1_nxt.oydx  = oy * dx;
    s1_nxt.oxdx  = ox * dx;
    s1_nxt.oydy  = oy * dy;
    s1_nxt.oxx   = ox * ox;
    s1_nxt.oyy   = oy * oy;
    s1_nxt.zlo_d = z_low_r - oz;
    s1_nxt.zhi_d = z_high_r - oz;
    s1_nxt.dz    = dz;
  end

  // Stage 2: a, b, c, the distance test and the z slab numerators.
  always_comb begin
    s2_nxt.valid     = s1_r.valid;
    s2_nxt.a         = s1_r.dxx + s1_r.dyy;
    s2_nxt.c         = s1_r.oxdy - s1_r.oydx;
    s2_nxt.b         = s1_r.oxdx + s1_r.oydy;
    s2_nxt.in_rad    = ({1'b0, s1_r.oxx} + {1'b0, s1_r.oyy}) < {3'b000, r2_r};
    s2_nxt.z.zzero   = (s1_r.dz == '0);
    s2_nxt.z.zinside = (s1_r.zlo_d < 0) && (s1_r.zhi_d > 0);
    s2_nxt.z.zden    = s1_r.dz[DIR_W-1] ? DIR_W'(-s1_r.dz) : DIR_W'(s1_r.dz);
    if (s1_r.dz[DIR_W-1]) begin
      s2_nxt.z.zin_num  = -s1_r.zhi_d;
      s2_nxt.z.zout_num = -s1_r.zlo_d;
    end else begin
      s2_nxt.z.zin_num  = s1_r.zlo_d;
      s2_nxt.z.zout_num = s1_r.zhi_d;
    end
  end

  // Stage 3: partial products of c^2 and a*R^2.
  assign cabs = s2_r.c[SUM_W-1] ? 49'(-s2_r.c) : 49'(s2_r.c);
  assign ch   = cabs[47:24];
  assign cl   = cabs[23:0];

  always_comb begin
    s3_nxt.valid  = s2_r.valid;
    s3_nxt.a      = s2_r.a;
    s3_nxt.b      = s2_r.b;
    s3_nxt.in_rad = s2_r.in_rad;
    s3_nxt.azero  = (s2_r.a == '0);
    s3_nxt.chh    = ch * ch;
    s3_nxt.chl    = ch * cl;
    s3_nxt.cll    = cl * cl;
    s3_nxt.arh    = s2_r.a * r2_r[R2_W-1:RAD_W];
    s3_nxt.arl    = s2_r.a * r2_r[RAD_W-1:0];
    s3_nxt.z      = s2_r.z;
  end

  // Stage 4: sum the partial products.
  always_comb begin
    s4_nxt.valid  = s3_r.valid;
    s4_nxt.a      = s3_r.a;
    s4_nxt.b      = s3_r.b;
    s4_nxt.in_rad = s3_r.in_rad;
    s4_nxt.azero  = s3_r.azero;
    s4_nxt.c2     = (96'(s3_r.chh) << 48) + (96'(s3_r.chl) << 25) + 96'(s3_r.cll);
    s4_nxt.ar2    = (94'(s3_r.arh) << RAD_W) + 94'(s3_r.arl);
    s4_nxt.z      = s3_r.z;
  end

  // Stage 5: discriminant and the choice of the inside or outside test.
  always_comb begin
    s5_nxt.valid  = s4_r.valid;
    s5_nxt.a      = s4_r.a;
    s5_nxt.b      = s4_r.b;
    s5_nxt.in_rad = s4_r.in_rad;
    s5_nxt.byp    = s4_r.azero || (s4_r.c2 >= 96'(s4_r.ar2));
    s5_nxt.z      = s4_r.z;
    disc_nxt      = SQ_IN_W'(96'(s4_r.ar2) - s4_r.c2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r  <= '0;
      s2_r  <= '0;
      s3_r  <= '0;
      s4_r  <= '0;
      sa_r[0] <= '0;
    end else if (en) begin
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      s3_r  <= s3_nxt;
      s4_r  <= s4_nxt;
      sa_r[0] <= s5_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      disc_r <= disc_nxt;
    end
  end

  rcc_isqrt u_isqrt (
    .clk      (clk),
    .en       (en),
    .radicand (disc_r),
    .root     (root)
  );

  // Side data that rides along with the square root.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= SQ_STEPS; i++) begin
        sa_r[i] <= '0;
      end
    end else if (en) begin
      for (int i = 1; i <= SQ_STEPS; i++) begin
        sa_r[i] <= sa_r[i-1];
      end
    end
  end

  // Radial numerators -b - root and -b + root, and the z slab numerators.
  assign nb       = -NUM_W'(sa_r[SQ_STEPS].b);
  assign num_in   = nb - NUM_W'(root);
  assign num_out  = nb + NUM_W'(root);
  assign abs_in   = num_in[NUM_W-1]  ? -num_in  : num_in;
  assign abs_out  = num_out[NUM_W-1] ? -num_out : num_out;
  assign zabs_in  = sa_r[SQ_STEPS].z.zin_num[COORD_W]
                    ? (COORD_W+1)'(-sa_r[SQ_STEPS].z.zin_num)
                    : (COORD_W+1)'(sa_r[SQ_STEPS].z.zin_num);
  assign zabs_out = sa_r[SQ_STEPS].z.zout_num[COORD_W]
                    ? (COORD_W+1)'(-sa_r[SQ_STEPS].z.zout_num)
                    : (COORD_W+1)'(sa_r[SQ_STEPS].z.zout_num);

  assign rdin_in.mag  = abs_in[MAG_W-1:0];
  assign rdin_in.den  = sa_r[SQ_STEPS].a;
  assign rdin_out.mag = abs_out[MAG_W-1:0];
  assign rdin_out.den = sa_r[SQ_STEPS].a;
  assign zdin_in.mag  = MAG_W'(zabs_in);
  assign zdin_in.den  = DEN_W'(sa_r[SQ_STEPS].z.zden);
  assign zdin_out.mag = MAG_W'(zabs_out);
  assign zdin_out.den = DEN_W'(sa_r[SQ_STEPS].z.zden);

  rcc_div u_div_rin  (.clk(clk), .en(en), .din(rdin_in),  .dout(rq_in));
  rcc_div u_div_rout (.clk(clk), .en(en), .din(rdin_out), .dout(rq_out));
  rcc_div u_div_zin  (.clk(clk), .en(en), .din(zdin_in),  .dout(zq_in));
  rcc_div u_div_zout (.clk(clk), .en(en), .din(zdin_out), .dout(zq_out));

  // Side data that rides along with the dividers.
  always_comb begin
    sb_nxt.valid    = sa_r[SQ_STEPS].valid;
    sb_nxt.byp      = sa_r[SQ_STEPS].byp;
    sb_nxt.in_rad   = sa_r[SQ_STEPS].in_rad;
    sb_nxt.rneg_in  = num_in[NUM_W-1];
    sb_nxt.rneg_out = num_out[NUM_W-1];
    sb_nxt.zneg_in  = sa_r[SQ_STEPS].z.zin_num[COORD_W];
    sb_nxt.zneg_out = sa_r[SQ_STEPS].z.zout_num[COORD_W];
    sb_nxt.zzero    = sa_r[SQ_STEPS].z.zzero;
    sb_nxt.zinside  = sa_r[SQ_STEPS].z.zinside;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= DIV_STEPS; i++) begin
        sb_r[i] <= '0;
      end
    end else if (en) begin
      sb_r[0] <= sb_nxt;
      for (int i = 1; i <= DIV_STEPS; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  // Interval ends, with the parallel and no-crossing cases replaced by the inside tests.
  always_comb begin
    f_nxt.valid = sb_r[DIV_STEPS].valid;
    if (sb_r[DIV_STEPS].byp) begin
      f_nxt.rin  = sb_r[DIV_STEPS].in_rad ? -VAL_INF : VAL_INF;
      f_nxt.rout = sb_r[DIV_STEPS].in_rad ? VAL_INF : -VAL_INF;
    end else begin
      f_nxt.rin  = div_val(sb_r[DIV_STEPS].rneg_in, rq_in);
      f_nxt.rout = div_val(sb_r[DIV_STEPS].rneg_out, rq_out);
    end
    if (sb_r[DIV_STEPS].zzero) begin
      f_nxt.zin  = sb_r[DIV_STEPS].zinside ? -VAL_INF : VAL_INF;
      f_nxt.zout = sb_r[DIV_STEPS].zinside ? VAL_INF : -VAL_INF;
    end else begin
      f_nxt.zin  = div_val(sb_r[DIV_STEPS].zneg_in, zq_in);
      f_nxt.zout = div_val(sb_r[DIV_STEPS].zneg_out, zq_out);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_r <= '0;
    end else if (en) begin
      f_r <= f_nxt;
    end
  end

  // Intersect the two intervals and saturate.
  assign ent  = (f_r.rin < f_r.zin) ? f_r.zin : f_r.rin;
  assign ext  = (f_r.rout < f_r.zout) ? f_r.rout : f_r.zout;
  assign miss = (f_r.rin >= f_r.rout) || (f_r.zin >= f_r.zout) || (ent >= ext);

  always_comb begin
    if (miss) begin
      s_enter_nxt = MISS_ENTER;
      s_exit_nxt  = MISS_EXIT;
      hit_nxt     = 1'b0;
    end else begin
      s_enter_nxt = sat(ent);
      s_exit_nxt  = sat(ext);
      hit_nxt     = 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= f_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_enter_r <= s_enter_nxt;
      s_exit_r  <= s_exit_nxt;
      hit_r     <= hit_nxt;
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = {s_exit_r, s_enter_r};
  assign out_tuser[0] = hit_r;

  // A miss always carries the fixed miss pattern.
  a_miss_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == {MISS_EXIT, MISS_ENTER})
    else $error("miss beat without the miss pattern");

  // A hit never shows an entry beyond its exit.
  a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> $signed(out_tdata[31:0]) <= $signed(out_tdata[63:32]))
    else $error("hit with entry after exit");

  // Input is refused only while an output beat is held.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input refused without an output stall");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire
